// File: design/oledg_pkg.sv
// shared types, codes and tables for the oled glyph command generator
`default_nettype none

package oledg_pkg;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_PIXEL = 2'd1,
		OP_CHAR  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	localparam int unsigned INIT_LEN  = 24;
	localparam int unsigned IDX_W     = $clog2(INIT_LEN);
	localparam int unsigned WIN_LEN   = 6;
	localparam int unsigned PIX_LAST  = 6;
	localparam int unsigned CHAR_LAST = 11;
	localparam int unsigned CHAR_W    = 5;

	localparam logic [7:0] CMD_COL_ADDR  = 8'h21;
	localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
	localparam logic [7:0] CHAR_X_MAX    = 8'd122;
	localparam logic [7:0] CHAR_Y_MAX    = 8'd56;

	typedef logic [IDX_W-1:0] idx_t;

	// leftmost column first
	typedef logic [0:CHAR_W-1][7:0] glyph_t;

	localparam glyph_t GLYPH_BOX = 40'h7F_00_00_00_7F;

	localparam logic [0:INIT_LEN-1][7:0] INIT_SEQ = {
		8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40,
		8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'hCF, 8'hD9, 8'hF1,
		8'hDB, 8'h40, 8'hA4, 8'hA6, 8'h20, 8'h00, 8'h2E, 8'hAF
	};

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] x_pos;
		logic [7:0] y_pos;
		logic       pixel_on;
		logic [7:0] char_code;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last_byte;
	} obyte_t;

	function automatic glyph_t font_glyph(input logic [7:0] code);
		glyph_t g;
		case (code)
			8'h20:   g = 40'h00_00_00_00_00;
			8'h25:   g = 40'h63_13_08_64_63;
			8'h2D:   g = 40'h00_08_08_08_00;
			8'h2E:   g = 40'h00_00_40_00_00;
			8'h2F:   g = 40'h40_30_08_06_01;
			8'h30:   g = 40'h3E_51_49_45_3E;
			8'h31:   g = 40'h00_42_7F_40_00;
			8'h32:   g = 40'h42_61_51_49_46;
			8'h33:   g = 40'h21_41_45_4B_31;
			8'h34:   g = 40'h18_14_12_7F_10;
			8'h35:   g = 40'h27_45_45_45_39;
			8'h36:   g = 40'h3C_4A_49_49_30;
			8'h37:   g = 40'h01_71_09_05_03;
			8'h38:   g = 40'h36_49_49_49_36;
			8'h39:   g = 40'h06_49_49_29_1E;
			8'h3A:   g = 40'h00_00_36_00_00;
			8'h41:   g = 40'h7E_11_11_11_7E;
			8'h42:   g = 40'h7F_49_49_49_36;
			8'h43:   g = 40'h3E_41_41_41_22;
			8'h44:   g = 40'h7F_41_41_22_1C;
			8'h45:   g = 40'h7F_49_49_49_41;
			8'h46:   g = 40'h7F_09_09_09_01;
			8'h47:   g = 40'h3E_41_49_49_7A;
			8'h48:   g = 40'h7F_08_08_08_7F;
			8'h49:   g = 40'h41_41_7F_41_41;
			8'h4A:   g = 40'h20_40_41_3F_01;
			8'h4B:   g = 40'h7F_08_14_22_41;
			8'h4C:   g = 40'h7F_40_40_40_40;
			8'h4D:   g = 40'h7F_02_0C_02_7F;
			8'h4E:   g = 40'h7F_04_08_10_7F;
			8'h4F:   g = 40'h3E_41_41_41_3E;
			8'h50:   g = 40'h7F_09_09_09_06;
			8'h51:   g = 40'h3E_41_51_21_5E;
			8'h52:   g = 40'h7F_09_19_29_46;
			8'h53:   g = 40'h46_49_49_49_31;
			8'h54:   g = 40'h01_01_7F_01_01;
			8'h55:   g = 40'h3F_40_40_40_3F;
			8'h56:   g = 40'h1F_20_40_20_1F;
			8'h57:   g = 40'h7F_20_18_20_7F;
			8'h58:   g = 40'h63_14_08_14_63;
			8'h59:   g = 40'h07_08_70_08_07;
			8'h5A:   g = 40'h61_51_49_45_43;
			default: g = GLYPH_BOX;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

// File: design/oled_glyph_command_generator.sv
// top level: request register, byte sequencer and output register
// A request (init, pixel or character) is held in a request register and
// played out through an output register, one controller byte per cycle
// while out_ready does not stall it: init gives 24 command bytes, a pixel
// write 7 bytes (six window commands and one data byte), a character write
// 12 bytes (six window commands, five glyph columns and one blank column).
// The byte position counter walks the request register, and the next
// request is taken in the same cycle the last byte of the current one moves
// into the output register, so runs follow each other with no gap.
// Requests that draw nothing (off-screen coordinates or the unused opcode)
// are taken and dropped.
`default_nettype none

module oled_glyph_command_generator (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] x_pos,
	input  wire logic [7:0] y_pos,
	input  wire logic       pixel_on,
	input  wire logic [7:0] char_code,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] out_byte,
	output      logic       is_data,
	output      logic       last_byte
);
	import oledg_pkg::*;

	// request stage
	req_t   req_s1;
	logic   req_valid_s1;
	idx_t   idx_q;

	// output stage
	obyte_t obyte_s2;
	logic   out_valid_s2;

	obyte_t gen;
	req_t   in_req;
	logic   in_xfer;
	logic   advance;
	logic   in_draws;

	assign in_req = '{
		opcode:    opcode_t'(opcode),
		x_pos:     x_pos,
		y_pos:     y_pos,
		pixel_on:  pixel_on,
		char_code: char_code
	};

	// does the incoming request produce any bytes at all
	always_comb begin
		case (in_req.opcode)
			OP_INIT:  in_draws = 1'b1;
			OP_PIXEL: in_draws = !x_pos[7] && (y_pos[7:6] == 2'b00);
			OP_CHAR:  in_draws = (x_pos <= CHAR_X_MAX) && (y_pos <= CHAR_Y_MAX);
			default:  in_draws = 1'b0;
		endcase
	end

	// output register free to load this cycle
	assign advance  = !out_valid_s2 || out_ready;
	// take a new request once the current run hands over its last byte
	assign in_ready = !req_valid_s1 || (advance && gen.last_byte);
	assign in_xfer  = in_valid && in_ready;

	oledg_byte_gen u_byte_gen (
		.req   (req_s1),
		.idx   (idx_q),
		.obyte (gen)
	);

	// request register and byte position counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			idx_q        <= '0;
		end else if (in_xfer) begin
			req_valid_s1 <= in_draws;
			idx_q        <= '0;
		end else if (req_valid_s1 && advance) begin
			if (gen.last_byte) begin
				req_valid_s1 <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			req_s1 <= in_req;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_valid_s1) begin
			obyte_s2 <= gen;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_byte  = obyte_s2.out_byte;
	assign is_data   = obyte_s2.is_data;
	assign last_byte = obyte_s2.last_byte;

	// position counter stays inside the longest run
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid_s1 |-> (idx_q < IDX_W'(INIT_LEN)))
		else $error("byte position past end of run");

	// a new request only overlaps the last byte of the current one
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && req_valid_s1) |-> (advance && gen.last_byte))
		else $error("request taken mid-run");

	// a transfer that is not the last byte is followed by the next byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_byte) |=> out_valid)
		else $error("gap inside a run");

	// the window commands are never marked as data
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid_s1 && (idx_q < IDX_W'(WIN_LEN))) |-> !gen.is_data)
		else $error("data byte inside window commands");

endmodule

`default_nettype wire

// File: design/oledg_byte_gen.sv
// byte selection for one position of a request's run
`default_nettype none

module oledg_byte_gen (
	input  wire oledg_pkg::req_t   req,
	input  wire oledg_pkg::idx_t   idx,
	output      oledg_pkg::obyte_t obyte
);
	import oledg_pkg::*;

	logic [7:0]  page;
	logic [7:0]  win_byte;
	logic [7:0]  last_col;
	logic [2:0]  col;
	glyph_t      glyph;
	logic [7:0]  pix_byte;

	assign page     = {3'd0, req.y_pos[7:3]};
	assign last_col = (req.opcode == OP_CHAR) ? 8'(req.x_pos + 8'(CHAR_W)) : req.x_pos;
	assign col      = 3'(idx - IDX_W'(WIN_LEN));
	assign glyph    = font_glyph(req.char_code);
	assign pix_byte = req.pixel_on ? (8'd1 << req.y_pos[2:0]) : 8'd0;

	always_comb begin
		case (idx)
			IDX_W'(0): win_byte = CMD_COL_ADDR;
			IDX_W'(1): win_byte = req.x_pos;
			IDX_W'(2): win_byte = last_col;
			IDX_W'(3): win_byte = CMD_PAGE_ADDR;
			default:   win_byte = page;
		endcase
	end

	always_comb begin
		obyte = '0;
		case (req.opcode)
			OP_INIT: begin
				obyte.out_byte  = INIT_SEQ[idx];
				obyte.last_byte = (idx == IDX_W'(INIT_LEN - 1));
			end
			OP_PIXEL: begin
				if (idx < IDX_W'(WIN_LEN)) begin
					obyte.out_byte = win_byte;
				end else begin
					obyte.out_byte = pix_byte;
					obyte.is_data  = 1'b1;
				end
				obyte.last_byte = (idx == IDX_W'(PIX_LAST));
			end
			OP_CHAR: begin
				if (idx < IDX_W'(WIN_LEN)) begin
					obyte.out_byte = win_byte;
				end else if (idx < IDX_W'(CHAR_LAST)) begin
					obyte.out_byte = glyph[col];
					obyte.is_data  = 1'b1;
				end else begin
					obyte.out_byte = 8'd0;
					obyte.is_data  = 1'b1;
				end
				obyte.last_byte = (idx == IDX_W'(CHAR_LAST));
			end
			default: obyte = '0;
		endcase
	end

endmodule

`default_nettype wire
